// ===== design/assert_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at an edge implies the consequent at the same edge.
`define PTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/pts_pkg.sv =====
// Types and constants shared by the task scheduler modules.
package pts_pkg;

    localparam int PRIO_W  = 8;
    localparam int DELAY_W = 32;
    localparam int TICKS_W = 32;
    localparam int MODE_W  = 2;
    localparam int SLEEP_W = 8;

    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP  = 2'd2;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_WAITING = 2'd2
    } task_status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CREATE,
        OP_TICK,
        OP_SLEEP,
        OP_SWITCH
    } cell_op_t;

    // Command broadcast to every cell.
    typedef struct packed {
        cell_op_t            op;
        logic [PRIO_W-1:0]   prio;
        logic                autostart;
        logic [SLEEP_W-1:0]  dticks;
    } cell_cmd_t;

    // Per-cell selects computed by the sequencer.
    typedef struct packed {
        logic alive;     // slot holds a created task
        logic count_en;  // slot is below the most recently created one
        logic target;    // create/sleep slot, or the task to demote on a switch
        logic promote;   // task to make running on a switch
    } cell_sel_t;

endpackage

// ===== design/priority_task_scheduler.sv =====
// Top level of the fixed-priority task scheduler: sequencer and row of task cells.
//
//  Channel | Direction | Handshake          | Word
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall  | mode, priority_req, autostart, delay_ticks
//  out     | output    | out_valid/out_stall| current_task, switched, create_ok,
//          |           |                    | task_count, tick_count
//
// A create or an ignored word goes through the execute and done steps; done writes the
// result register. A tick or sleep word goes through execute, scan, apply and done;
// the best-task search walks the row of cells one slot per cycle, so the slot count
// sets the scan length. The next word is taken in the cycle after the result is written,
// even while still stalled; an output stall only holds the sequencer in its last step.
// Reset puts every slot in the ready state, no task created, no task running.
module priority_task_scheduler #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pts_pkg::MODE_W-1:0]         mode,
    input  logic [pts_pkg::PRIO_W-1:0]         priority_req,
    input  logic                               autostart,
    input  logic [pts_pkg::SLEEP_W-1:0]        delay_ticks,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [$clog2(TASK_SLOTS+1)-1:0]    current_task,
    output logic                               switched,
    output logic                               create_ok,
    output logic [$clog2(TASK_SLOTS+1)-1:0]    task_count,
    output logic [pts_pkg::TICKS_W-1:0]        tick_count
);

    `include "assert_macros.svh"

    // Index width holds every slot number plus the "none" value TASK_SLOTS.
    localparam int IDX_W = $clog2(TASK_SLOTS + 1);
    localparam int CNT_W = $clog2(TASK_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_APPLY,
        S_DONE
    } seq_state_t;

    seq_state_t                      state_reg;
    logic [pts_pkg::MODE_W-1:0]      mode_reg;
    logic [pts_pkg::PRIO_W-1:0]      prio_reg;
    logic                            autostart_reg;
    logic [pts_pkg::SLEEP_W-1:0]     dticks_reg;
    logic [CNT_W-1:0]                scan_cnt_reg;
    logic [IDX_W-1:0]                created_reg;
    logic [IDX_W-1:0]                running_reg;
    logic [pts_pkg::TICKS_W-1:0]     ticks_reg;
    logic                            switched_reg;
    logic                            create_ok_reg;
    logic                            out_valid_reg;
    logic [IDX_W-1:0]                out_task_reg;
    logic                            out_switched_reg;
    logic                            out_create_ok_reg;
    logic [IDX_W-1:0]                out_count_reg;
    logic [pts_pkg::TICKS_W-1:0]     out_ticks_reg;

    logic                            in_accept;
    logic                            out_load;
    logic                            table_full;
    logic                            do_switch;
    logic [IDX_W-1:0]                target_idx;
    pts_pkg::cell_cmd_t              cmd;
    pts_pkg::cell_sel_t              sel [TASK_SLOTS];

    // Best-task chain: entry 0 is empty, entry TASK_SLOTS is the search result.
    logic                            chain_valid [TASK_SLOTS+1];
    logic [pts_pkg::PRIO_W-1:0]      chain_prio  [TASK_SLOTS+1];
    logic [IDX_W-1:0]                chain_idx   [TASK_SLOTS+1];

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign table_full = (created_reg == IDX_W'(TASK_SLOTS));

    // The result register takes a new word in the last step once it is free.
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // The search leaves the running task in place when nothing is eligible or
    // when the winner is already running.
    assign do_switch  = chain_valid[TASK_SLOTS] && (chain_idx[TASK_SLOTS] != running_reg);

    // A create targets the next free slot; a sleep or a switch targets the
    // running task. A running index of TASK_SLOTS matches no cell.
    assign target_idx = (state_reg == S_EXEC && mode_reg == pts_pkg::MODE_CREATE)
                        ? created_reg : running_reg;

    always_comb
    begin
        cmd.op        = pts_pkg::OP_NONE;
        cmd.prio      = prio_reg;
        cmd.autostart = autostart_reg;
        cmd.dticks    = dticks_reg;
        case (state_reg)
            S_EXEC:
            begin
                case (mode_reg)
                    pts_pkg::MODE_CREATE:
                    begin
                        if (!table_full)
                        begin
                            cmd.op = pts_pkg::OP_CREATE;
                        end
                    end
                    pts_pkg::MODE_TICK:  cmd.op = pts_pkg::OP_TICK;
                    pts_pkg::MODE_SLEEP: cmd.op = pts_pkg::OP_SLEEP;
                    default:             cmd.op = pts_pkg::OP_NONE;
                endcase
            end
            S_APPLY:
            begin
                if (do_switch)
                begin
                    cmd.op = pts_pkg::OP_SWITCH;
                end
            end
            default:
            begin
                cmd.op = pts_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            sel[i].alive    = IDX_W'(i) < created_reg;
            // The most recently created task is never counted down.
            sel[i].count_en = IDX_W'(i + 1) < created_reg;
            sel[i].target   = IDX_W'(i) == target_idx;
            sel[i].promote  = IDX_W'(i) == chain_idx[TASK_SLOTS];
        end
    end

    assign chain_valid[0] = 1'b0;
    assign chain_prio[0]  = '0;
    assign chain_idx[0]   = '0;

    for (genvar g = 0; g < TASK_SLOTS; g++)
    begin : g_cell
        pts_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (sel[g]),
            .in_valid  (chain_valid[g]),
            .in_prio   (chain_prio[g]),
            .in_idx    (chain_idx[g]),
            .out_valid (chain_valid[g+1]),
            .out_prio  (chain_prio[g+1]),
            .out_idx   (chain_idx[g+1])
        );
    end

    // Sequencer: one word at a time. After a tick or sleep the cell state is
    // held still through the scan step so the search result at the end of the
    // row reflects the updated slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            created_reg   <= '0;
            running_reg   <= IDX_W'(TASK_SLOTS);
            ticks_reg     <= '0;
            switched_reg  <= 1'b0;
            create_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        switched_reg  <= 1'b0;
                        create_ok_reg <= 1'b0;
                        state_reg     <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    scan_cnt_reg <= CNT_W'(TASK_SLOTS - 1);
                    case (mode_reg)
                        pts_pkg::MODE_CREATE:
                        begin
                            if (!table_full)
                            begin
                                created_reg   <= created_reg + 1'b1;
                                create_ok_reg <= 1'b1;
                            end
                            state_reg <= S_DONE;
                        end
                        pts_pkg::MODE_TICK:
                        begin
                            ticks_reg <= ticks_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end
                        pts_pkg::MODE_SLEEP:
                        begin
                            state_reg <= S_SCAN;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg - 1'b1;
                    if (scan_cnt_reg == '0)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (do_switch)
                    begin
                        running_reg  <= chain_idx[TASK_SLOTS];
                        switched_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item word and result word payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg      <= mode;
            prio_reg      <= priority_req;
            autostart_reg <= autostart;
            dticks_reg    <= delay_ticks;
        end
        if (out_load)
        begin
            out_task_reg      <= running_reg;
            out_switched_reg  <= switched_reg;
            out_create_ok_reg <= create_ok_reg;
            out_count_reg     <= created_reg;
            out_ticks_reg     <= ticks_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_task = out_task_reg;
    assign switched     = out_switched_reg;
    assign create_ok    = out_create_ok_reg;
    assign task_count   = out_count_reg;
    assign tick_count   = out_ticks_reg;

    `PTS_ASSERT_ALWAYS(a_created_bounded, created_reg <= IDX_W'(TASK_SLOTS),
        "task count exceeds slot count")
    `PTS_ASSERT_IMPLIES(a_switch_has_task, out_valid && switched,
        current_task != IDX_W'(TASK_SLOTS), "switch reported with no running task")
    `PTS_ASSERT_IMPLIES(a_create_no_switch, out_valid && create_ok, !switched,
        "create reported together with a switch")
    `PTS_ASSERT_IMPLIES(a_tick_source, ticks_reg != $past(ticks_reg),
        $past(state_reg == S_EXEC && mode_reg == pts_pkg::MODE_TICK),
        "tick count moved outside a tick word")

endmodule

// ===== design/pts_cell.sv =====
// One task slot: status, priority and delay, plus one stage of the best-task chain.
module pts_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pts_pkg::cell_cmd_t         cmd,
    input  pts_pkg::cell_sel_t         sel,
    input  logic                       in_valid,
    input  logic [pts_pkg::PRIO_W-1:0] in_prio,
    input  logic [IDX_W-1:0]           in_idx,
    output logic                       out_valid,
    output logic [pts_pkg::PRIO_W-1:0] out_prio,
    output logic [IDX_W-1:0]           out_idx
);

    pts_pkg::task_status_t         status_reg;
    logic [pts_pkg::PRIO_W-1:0]    prio_reg;
    logic [pts_pkg::DELAY_W-1:0]   delay_reg;
    logic                          out_valid_reg;
    logic [pts_pkg::PRIO_W-1:0]    out_prio_reg;
    logic [IDX_W-1:0]              out_idx_reg;

    logic                          eligible;
    logic                          take;
    logic [pts_pkg::DELAY_W-1:0]   delay_dec;

    assign eligible  = sel.alive && (status_reg == pts_pkg::ST_READY ||
                                     status_reg == pts_pkg::ST_RUNNING);
    // Later slots win ties, so an equal priority replaces the incoming best.
    assign take      = eligible && (!in_valid || prio_reg >= in_prio);
    assign delay_dec = delay_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= pts_pkg::ST_READY;
        end
        else
        begin
            case (cmd.op)
                pts_pkg::OP_CREATE:
                begin
                    if (sel.target)
                    begin
                        status_reg <= cmd.autostart ? pts_pkg::ST_READY
                                                    : pts_pkg::ST_WAITING;
                    end
                end
                pts_pkg::OP_TICK:
                begin
                    if (sel.count_en && status_reg == pts_pkg::ST_WAITING &&
                        delay_dec == '0)
                    begin
                        status_reg <= pts_pkg::ST_READY;
                    end
                end
                pts_pkg::OP_SLEEP:
                begin
                    if (sel.target)
                    begin
                        status_reg <= pts_pkg::ST_WAITING;
                    end
                end
                pts_pkg::OP_SWITCH:
                begin
                    if (sel.promote)
                    begin
                        status_reg <= pts_pkg::ST_RUNNING;
                    end
                    else if (sel.target && status_reg == pts_pkg::ST_RUNNING)
                    begin
                        status_reg <= pts_pkg::ST_READY;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pts_pkg::OP_CREATE:
            begin
                if (sel.target)
                begin
                    prio_reg  <= cmd.prio;
                    delay_reg <= '0;
                end
            end
            pts_pkg::OP_TICK:
            begin
                if (sel.count_en && status_reg == pts_pkg::ST_WAITING)
                begin
                    delay_reg <= delay_dec;
                end
            end
            pts_pkg::OP_SLEEP:
            begin
                if (sel.target)
                begin
                    delay_reg <= pts_pkg::DELAY_W'(cmd.dticks);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Best-task stage, refreshed every cycle from the left neighbor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid || eligible;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prio_reg <= take ? prio_reg : in_prio;
        out_idx_reg  <= take ? IDX_W'(CELL_IDX) : in_idx;
    end

    assign out_valid = out_valid_reg;
    assign out_prio  = out_prio_reg;
    assign out_idx   = out_idx_reg;

endmodule

// ===== tb/sv/priority_task_scheduler_test.sv =====
// Self-checking testbench for the fixed-priority task scheduler, with a scheduler predictor.
module priority_task_scheduler_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 8;
    localparam int CUR_W       = $clog2(SLOTS + 1);
    localparam int SCHED_WORDS = 1427;   // words in the random part
    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int REPORT_CAP  = 100;    // keeps a badly broken run readable

    // Mode codes under short names for the stimulus table.
    localparam logic [pts_pkg::MODE_W-1:0] MODE_CREATE = pts_pkg::MODE_CREATE;
    localparam logic [pts_pkg::MODE_W-1:0] MODE_TICK   = pts_pkg::MODE_TICK;
    localparam logic [pts_pkg::MODE_W-1:0] MODE_SLEEP  = pts_pkg::MODE_SLEEP;
    // Mode 3 has no meaning; the block answers it with a plain status word.
    localparam logic [pts_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    // A task index equal to the slot count means no task is running yet.
    localparam logic [CUR_W-1:0]  NO_TASK     = CUR_W'(SLOTS);

    // One result word, field for field as the block presents it.
    typedef struct packed {
        logic [CUR_W-1:0]            current;
        logic                        switched;
        logic                        create_ok;
        logic [CUR_W-1:0]            count;
        logic [pts_pkg::TICKS_W-1:0] ticks;
    } sched_out_t;

    // One stimulus word. When typed is set, want is the result read straight off
    // the behavior; otherwise the predictor supplies the expectation.
    typedef struct packed {
        logic [pts_pkg::MODE_W-1:0]  mode;
        logic [pts_pkg::PRIO_W-1:0]  prio;
        logic                        start_ready;
        logic [pts_pkg::SLEEP_W-1:0] nap;
        logic                        typed;
        sched_out_t                  want;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [pts_pkg::MODE_W-1:0]    mode = '0;
    logic [pts_pkg::PRIO_W-1:0]    priority_req = '0;
    logic                          autostart = 1'b0;
    logic [pts_pkg::SLEEP_W-1:0]   delay_ticks = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [CUR_W-1:0]              current_task;
    logic                          switched;
    logic                          create_ok;
    logic [CUR_W-1:0]              task_count;
    logic [pts_pkg::TICKS_W-1:0]   tick_count;

    // Predictor state: a private copy of the task table and the scheduler registers.
    pts_pkg::task_status_t         slot_state [SLOTS];
    logic [pts_pkg::PRIO_W-1:0]    slot_prio  [SLOTS];
    logic [pts_pkg::DELAY_W-1:0]   slot_delay [SLOTS];
    int                            n_created;
    logic [CUR_W-1:0]              run_slot;
    logic [CUR_W-1:0]              pick_slot;
    logic [pts_pkg::TICKS_W-1:0]   tick_total;

    sched_out_t           outcomes_due [$];
    int                   fault_count = 0;
    int                   idle_phase = 0;   // 0: sender idles lightly, 1: receiver does, 2: none

    // Directed part. The opening rows run with nothing created, then the table is
    // filled, exercising both start states, equal priorities, the slot that was
    // created last (which is never counted down), a sleep of zero ticks (the task
    // then waits a full 32-bit wrap) and a create refused because the table is full.
    stim_row_t directed_rows [23] = '{
        // Ignored mode before anything exists: every field shows the reset state.
        '{MODE_UNUSED, 8'd255, 1'b1, 8'd255, 1'b1, '{NO_TASK, 1'b0, 1'b0, 4'd0, 32'd0}},
        // Tick and sleep with no task at all: only the tick count moves.
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b1, '{NO_TASK, 1'b0, 1'b0, 4'd0, 32'd1}},
        '{MODE_SLEEP,  8'd0,   1'b0, 8'd0,   1'b1, '{NO_TASK, 1'b0, 1'b0, 4'd0, 32'd1}},
        // Creates never schedule, so nothing runs yet.
        '{MODE_CREATE, 8'd0,   1'b1, 8'd0,   1'b1, '{NO_TASK, 1'b0, 1'b1, 4'd1, 32'd1}},
        '{MODE_CREATE, 8'd255, 1'b0, 8'd0,   1'b1, '{NO_TASK, 1'b0, 1'b1, 4'd2, 32'd1}},
        // First switch: slot 0 is the only eligible task and nothing is demoted.
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b1, '{4'd0,    1'b1, 1'b0, 4'd2, 32'd2}},
        '{MODE_CREATE, 8'd128, 1'b1, 8'd0,   1'b0, '0},
        '{MODE_CREATE, 8'd128, 1'b1, 8'd0,   1'b0, '0},
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b0, '0},
        '{MODE_SLEEP,  8'd0,   1'b0, 8'd2,   1'b0, '0},
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b0, '0},
        '{MODE_CREATE, 8'd64,  1'b1, 8'd0,   1'b0, '0},
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b0, '0},
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b0, '0},
        '{MODE_CREATE, 8'd200, 1'b1, 8'd0,   1'b0, '0},
        '{MODE_CREATE, 8'd200, 1'b1, 8'd0,   1'b0, '0},
        '{MODE_CREATE, 8'd1,   1'b1, 8'd0,   1'b0, '0},
        // Table full: the create is refused and the state stands still.
        '{MODE_CREATE, 8'd255, 1'b1, 8'd0,   1'b1, '{4'd3,    1'b0, 1'b0, 4'd8, 32'd6}},
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b0, '0},
        '{MODE_SLEEP,  8'd0,   1'b0, 8'd255, 1'b0, '0},
        '{MODE_SLEEP,  8'd0,   1'b0, 8'd0,   1'b0, '0},
        '{MODE_SLEEP,  8'd0,   1'b0, 8'd1,   1'b0, '0},
        '{MODE_TICK,   8'd0,   1'b0, 8'd0,   1'b0, '0}
    };

    priority_task_scheduler #(
        .TASK_SLOTS (SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .priority_req (priority_req),
        .autostart    (autostart),
        .delay_ticks  (delay_ticks),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .current_task (current_task),
        .switched     (switched),
        .create_ok    (create_ok),
        .task_count   (task_count),
        .tick_count   (tick_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Picks the ready or running task with the highest priority, the highest index
    // winning a tie, and performs the switch if the choice differs from the running
    // task. With no eligible task the previous choice is kept. Returns 1 on a switch.
    function automatic logic pick_and_switch();
        int best;
        int i;
        best = 0;
        for (i = 0; i < n_created; i++)
        begin
            if ((slot_state[i] == pts_pkg::ST_READY || slot_state[i] == pts_pkg::ST_RUNNING)
                    && slot_prio[i] >= best)
            begin
                best      = slot_prio[i];
                pick_slot = CUR_W'(i);
            end
        end
        if (run_slot == pick_slot || pick_slot >= SLOTS)
            return 1'b0;
        // On the first switch there is no previous task to put back.
        if (run_slot < SLOTS && slot_state[run_slot] == pts_pkg::ST_RUNNING)
            slot_state[run_slot] = pts_pkg::ST_READY;
        run_slot             = pick_slot;
        slot_state[run_slot] = pts_pkg::ST_RUNNING;
        return 1'b1;
    endfunction

    // Advances the predicted scheduler by one accepted word and returns its result.
    function automatic sched_out_t apply_word(input stim_row_t w);
        sched_out_t r;
        int         i;
        r = '0;
        case (w.mode)
            MODE_CREATE:
            begin
                if (n_created < SLOTS)
                begin
                    slot_state[n_created] = w.start_ready ? pts_pkg::ST_READY
                                                          : pts_pkg::ST_WAITING;
                    slot_prio[n_created]  = w.prio;
                    slot_delay[n_created] = '0;
                    n_created++;
                    r.create_ok = 1'b1;
                end
            end
            MODE_TICK:
            begin
                tick_total++;
                // The slot created last is left out of the count-down.
                for (i = 0; i + 1 < n_created; i++)
                begin
                    if (slot_state[i] == pts_pkg::ST_WAITING)
                    begin
                        slot_delay[i] = slot_delay[i] - 1'b1;
                        if (slot_delay[i] == '0)
                            slot_state[i] = pts_pkg::ST_READY;
                    end
                end
                r.switched = pick_and_switch();
            end
            MODE_SLEEP:
            begin
                // With nothing running the sleep only triggers a scheduling pass.
                if (run_slot < SLOTS)
                begin
                    slot_state[run_slot] = pts_pkg::ST_WAITING;
                    slot_delay[run_slot] = pts_pkg::DELAY_W'(w.nap);
                end
                r.switched = pick_and_switch();
            end
            default:
            begin
            end
        endcase
        r.current = run_slot;
        r.count   = CUR_W'(n_created);
        r.ticks   = tick_total;
        return r;
    endfunction

    function automatic void check_field(input string tag, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
        end
    endfunction

    // Offers one word on the input channel, after a random idle stretch, and holds it
    // until the block takes it. The expectation is queued at the accepting edge.
    task automatic send_word(input stim_row_t w);
        int send_pct;
        send_pct = (idle_phase == 0) ? 13 : (idle_phase == 1) ? 59 : 0;
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= w.mode;
        priority_req <= w.prio;
        autostart    <= w.start_ready;
        delay_ticks  <= w.nap;
        do
            @(posedge clk);
        while (in_stall);
        outcomes_due.push_back(w.typed ? w.want : apply_word(w));
        // The predictor has to move on typed rows as well.
        if (w.typed)
            void'(apply_word(w));
    endtask

    // Output side: checks each accepted result word against the oldest expectation,
    // drives the receiver stall and watches for a hung handshake.
    always @(posedge clk)
    begin
        int         recv_pct;
        int         quiet;
        sched_out_t due;
        recv_pct = (idle_phase == 0) ? 59 : (idle_phase == 1) ? 13 : 0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (outcomes_due.size() == 0)
                begin
                    fault_count++;
                    $display("%0t ns: result word with nothing expected, current_task %0d",
                             $time, current_task);
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    check_field("current_task", 32'(due.current), 32'(current_task));
                    check_field("switched", 32'(due.switched), 32'(switched));
                    check_field("create_ok", 32'(due.create_ok), 32'(create_ok));
                    check_field("task_count", 32'(due.count), 32'(task_count));
                    check_field("tick_count", due.ticks, tick_count);
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    initial
    begin
        int        k;
        int        sched_words;
        int        roll;
        int        span;
        stim_row_t w;
        sched_words = 0;
        for (k = 0; k < SLOTS; k++)
        begin
            slot_state[k] = pts_pkg::ST_READY;
            slot_prio[k]  = '0;
            slot_delay[k] = '0;
        end
        n_created  = 0;
        run_slot   = NO_TASK;
        pick_slot  = NO_TASK;
        tick_total = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < $size(directed_rows); k++)
            send_word(directed_rows[k]);

        // Random part. The table is full by now, so ticks and sleeps carry the run;
        // sleeps are mostly short so that tasks keep waking and preempting each
        // other. Refused creates and unused-mode words are mixed in as noise.
        while (sched_words < SCHED_WORDS)
        begin
            roll = $urandom_range(99);
            span = $urandom_range(99);
            w    = '0;
            if (roll < 70)
                w.mode = MODE_TICK;
            else if (roll < 90)
                w.mode = MODE_SLEEP;
            else if (roll < 95)
                w.mode = MODE_CREATE;
            else
                w.mode = MODE_UNUSED;
            w.prio        = pts_pkg::PRIO_W'($urandom_range(255));
            w.start_ready = 1'($urandom_range(1));
            if (span < 75)
                w.nap = pts_pkg::SLEEP_W'($urandom_range(4, 1));
            else if (span < 97)
                w.nap = pts_pkg::SLEEP_W'($urandom_range(30, 5));
            else
                w.nap = pts_pkg::SLEEP_W'($urandom_range(255, 31));
            send_word(w);
            sched_words++;
            idle_phase = sched_words * 3 / SCHED_WORDS;
        end
        in_valid <= 1'b0;

        // Drain: wait for every expected word, then a little longer so that a
        // stray extra result would still be caught.
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
